// ===== hw/rtl/plfp_pkg.sv =====
// plfp_pkg: shared types and codes for the panel link frame parser.
// No dependencies; used by every module of the block.
package plfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int THIRD_W = 9;

    // Frame kind codes as reported on frame_kind
    localparam logic [KIND_W-1:0] KIND_SENSOR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LINK    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SETTEMP = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COMMAND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLOCK   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FAN     = 3'd5;

    // Header and type characters
    localparam logic [BYTE_W-1:0] CHR_HDR0    = 8'h4D; // 'M'
    localparam logic [BYTE_W-1:0] CHR_HDR1    = 8'h41; // 'A'
    localparam logic [BYTE_W-1:0] CHR_SENSOR  = 8'h44; // 'D'
    localparam logic [BYTE_W-1:0] CHR_LINK    = 8'h57; // 'W'
    localparam logic [BYTE_W-1:0] CHR_SETTEMP = 8'h50; // 'P'
    localparam logic [BYTE_W-1:0] CHR_COMMAND = 8'h43; // 'C'
    localparam logic [BYTE_W-1:0] CHR_CLOCK   = 8'h42; // 'B'
    localparam logic [BYTE_W-1:0] CHR_FAN     = 8'h53; // 'S'

    localparam logic [BYTE_W-1:0]  LINK_UP_CODE = 8'h01;
    localparam logic [THIRD_W-1:0] SEC_OFFSET   = 9'd2;

    // Decoded frame as it leaves the parser
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  first;
        logic [BYTE_W-1:0]  second;
        logic [THIRD_W-1:0] third;
        logic               hours;
        logic               minutes;
    } result_t;

endpackage

// ===== hw/rtl/plfp_parser.sv =====
// plfp_parser: frame state machine and payload decode, one byte per cycle while accept is high.
// Depends on plfp_pkg.
module plfp_parser
    import plfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              hold_clock,
    output logic              push,
    output result_t           res
);

    typedef enum logic [5:0] {
        PH_HDR0  = 6'b000001,
        PH_HDR1  = 6'b000010,
        PH_TYPE  = 6'b000100,
        PH_PAY1  = 6'b001000,
        PH_PAY2  = 6'b010000,
        PH_PAY3  = 6'b100000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [BYTE_W-1:0]  first_reg, first_next;
    logic [BYTE_W-1:0]  second_reg, second_next;
    logic               hours_reg, hours_next;
    logic               minutes_reg, minutes_next;
    logic               take;
    logic               emit;

    assign take = ~hold_clock;

    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        hours_next   = hours_reg;
        minutes_next = minutes_reg;
        emit         = 1'b0;
        res          = '0;
        unique case (phase_reg)
            PH_HDR0:
            begin
                if (rx_byte == CHR_HDR0)
                    phase_next = PH_HDR1;
            end
            PH_HDR1:
            begin
                phase_next = (rx_byte == CHR_HDR1) ? PH_TYPE : PH_HDR0;
            end
            PH_TYPE:
            begin
                phase_next = PH_PAY1;
                priority if (rx_byte == CHR_SENSOR)  kind_next = KIND_SENSOR;
                else if (rx_byte == CHR_LINK)        kind_next = KIND_LINK;
                else if (rx_byte == CHR_SETTEMP)     kind_next = KIND_SETTEMP;
                else if (rx_byte == CHR_COMMAND)     kind_next = KIND_COMMAND;
                else if (rx_byte == CHR_CLOCK)       kind_next = KIND_CLOCK;
                else if (rx_byte == CHR_FAN)         kind_next = KIND_FAN;
                else                                 phase_next = PH_HDR0;
            end
            PH_PAY1:
            begin
                phase_next = PH_HDR0;
                priority if (kind_reg == KIND_SENSOR)
                begin
                    first_next = rx_byte;
                    phase_next = PH_PAY2;
                end
                else if (kind_reg == KIND_CLOCK)
                begin
                    first_next = rx_byte;
                    hours_next = take;
                    phase_next = PH_PAY2;
                end
                else if (kind_reg == KIND_LINK)
                begin
                    emit      = 1'b1;
                    res.kind  = KIND_LINK;
                    res.first = {{(BYTE_W-1){1'b0}}, (rx_byte == LINK_UP_CODE)};
                end
                else if (kind_reg == KIND_SETTEMP || kind_reg == KIND_COMMAND ||
                         kind_reg == KIND_FAN)
                begin
                    emit      = 1'b1;
                    res.kind  = kind_reg;
                    res.first = rx_byte;
                end
            end
            PH_PAY2:
            begin
                phase_next = PH_HDR0;
                priority if (kind_reg == KIND_CLOCK)
                begin
                    second_next  = rx_byte;
                    minutes_next = take;
                    phase_next   = PH_PAY3;
                end
                else if (kind_reg == KIND_SENSOR)
                begin
                    emit       = 1'b1;
                    res.kind   = KIND_SENSOR;
                    res.first  = first_reg;
                    res.second = rx_byte;
                end
            end
            PH_PAY3:
            begin
                phase_next = PH_HDR0;
                if (kind_reg == KIND_CLOCK)
                begin
                    emit        = 1'b1;
                    res.kind    = KIND_CLOCK;
                    res.first   = first_reg;
                    res.second  = second_reg;
                    res.third   = {1'b0, rx_byte} + SEC_OFFSET;
                    res.hours   = hours_reg;
                    res.minutes = minutes_reg;
                end
            end
            default:
            begin
                phase_next = PH_HDR0;
            end
        endcase
    end

    assign push = accept & emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            kind_reg    <= KIND_SENSOR;
            first_reg   <= '0;
            second_reg  <= '0;
            hours_reg   <= 1'b0;
            minutes_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            hours_reg   <= hours_next;
            minutes_reg <= minutes_next;
        end
    end

`ifndef SYNTH
    // a byte beyond the type byte only follows a valid kind
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_HDR0 && phase_reg != PH_HDR1 && phase_reg != PH_TYPE)
        |-> (kind_reg <= KIND_FAN))
        else $error("held kind out of range");
    // third payload byte belongs to clock frames only
    a_pay3_clock: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAY3) |-> (kind_reg == KIND_CLOCK))
        else $error("third payload outside clock frame");
    // every result closes the frame
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (phase_reg == PH_HDR0))
        else $error("parser not idle after result");
`endif

endmodule

// ===== hw/rtl/plfp_out_buf.sv =====
// plfp_out_buf: result register with one skid entry behind it.
// Depends on plfp_pkg.
module plfp_out_buf
    import plfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_res,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop  = out_valid_reg & out_ready;
    assign room = ~skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = push;
                skid_next       = push_res;
            end
            else
            begin
                out_valid_next = push;
                out_next       = push_res;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

`ifndef SYNTH
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without head entry");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into full buffer");
    a_third_clock: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind != KIND_CLOCK) |-> (out_reg.third == '0))
        else $error("seconds reported outside clock frame");
`endif

endmodule

// ===== hw/rtl/panel_link_frame_parser_core.sv =====
// panel_link_frame_parser_core: top level of the panel link frame parser.
// Depends on plfp_pkg, plfp_parser and plfp_out_buf.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  input   | in_valid / in_ready  | rx_byte, hold_clock
//  output  | out_valid / out_ready| frame_kind, first_value, second_value,
//          |                      | third_value, hours_taken, minutes_taken
//
// One item (a byte) is accepted per cycle while in_ready is high; the parser
// state updates in that same cycle and a finished frame is registered into the
// result or skid register. Reset (rst_n, async, active low) returns the parser
// to header search and empties the result buffer. A stalled output is absorbed
// by one skid entry, so in_ready drops only when both result slots are full.
//
// Frame: 'M' 'A' type payload. Types: 'D' sensor (humidity, temperature),
// 'W' link status, 'P' set temperature, 'C' command, 'S' fan speed,
// 'B' clock (hours, minutes, seconds+2). Hours and minutes are flagged as
// taken only while hold_clock is low on arrival.
module panel_link_frame_parser_core
    import plfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [BYTE_W-1:0]  rx_byte,
    input  logic               hold_clock,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  frame_kind,
    output logic [BYTE_W-1:0]  first_value,
    output logic [BYTE_W-1:0]  second_value,
    output logic [THIRD_W-1:0] third_value,
    output logic               hours_taken,
    output logic               minutes_taken
);

    logic    accept;
    logic    push;
    logic    room;
    result_t push_res;
    result_t out_res;

    // bytes flow whenever a result slot is free
    assign in_ready = room;
    assign accept   = in_valid & room;

    plfp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .hold_clock (hold_clock),
        .push       (push),
        .res        (push_res)
    );

    plfp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (push_res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign frame_kind    = out_res.kind;
    assign first_value   = out_res.first;
    assign second_value  = out_res.second;
    assign third_value   = out_res.third;
    assign hours_taken   = out_res.hours;
    assign minutes_taken = out_res.minutes;

endmodule

// ===== tb/tb_panel_link_frame_parser_core.sv =====
`timescale 1ns / 100ps
// tb_panel_link_frame_parser_core: self-checking bench for the panel link frame parser.
// Depends on plfp_pkg and panel_link_frame_parser_core; runs directed frames, a back-to-back
// burst, then random traffic, and checks every decoded frame against a local decoder.
module tb_panel_link_frame_parser_core;
    import plfp_pkg::*;

    localparam int CLK_HALF    = 4;       // 8 ns period
    localparam int CYCLE_LIMIT = 200000;  // far above the slowest legal run
    localparam int TAIL_CYCLES = 8;       // idle time after the last due frame is taken
    localparam int ITEM_TARGET = 1750;

    // Decoder phases, mirror of the parser's frame position
    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_TYPE,
        PH_PAY1,
        PH_PAY2,
        PH_PAY3
    } phase_e;

    localparam logic [BYTE_W-1:0] TYPE_CHRS [6] = '{
        CHR_SENSOR, CHR_LINK, CHR_SETTEMP, CHR_COMMAND, CHR_CLOCK, CHR_FAN
    };

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic [BYTE_W-1:0]  rx_byte    = '0;
    logic               hold_clock = 1'b0;
    logic               out_ready  = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic [KIND_W-1:0]  frame_kind;
    logic [BYTE_W-1:0]  first_value;
    logic [BYTE_W-1:0]  second_value;
    logic [THIRD_W-1:0] third_value;
    logic               hours_taken;
    logic               minutes_taken;

    // Frames the decoder says must come out, oldest first
    result_t frames_due[$];

    // Local decoder state
    phase_e            dec_phase  = PH_HDR0;
    logic [KIND_W-1:0] dec_kind   = '0;
    logic [BYTE_W-1:0] dec_first  = '0;
    logic [BYTE_W-1:0] dec_second = '0;
    logic              dec_hours  = 1'b0;
    logic              dec_mins   = 1'b0;

    int fail_count = 0;
    int bytes_sent = 0;
    int cycles     = 0;
    bit idle_on    = 1'b1;  // random gaps on both sides when set

    panel_link_frame_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .hold_clock    (hold_clock),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_kind    (frame_kind),
        .first_value   (first_value),
        .second_value  (second_value),
        .third_value   (third_value),
        .hours_taken   (hours_taken),
        .minutes_taken (minutes_taken)
    );

    always #(CLK_HALF) clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Decode one accepted byte; a finished frame is queued as expected output.
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic hold);
        result_t r;
        bit      done;
        logic    take;
        r    = '0;
        done = 1'b0;
        take = ~hold;
        case (dec_phase)
            PH_HDR0:
            begin
                if (b == CHR_HDR0)
                    dec_phase = PH_HDR1;
            end
            PH_HDR1:
            begin
                // anything but 'A' (a repeated 'M' too) restarts the header search
                dec_phase = (b == CHR_HDR1) ? PH_TYPE : PH_HDR0;
            end
            PH_TYPE:
            begin
                dec_phase = PH_PAY1;
                case (b)
                    CHR_SENSOR:  dec_kind = KIND_SENSOR;
                    CHR_LINK:    dec_kind = KIND_LINK;
                    CHR_SETTEMP: dec_kind = KIND_SETTEMP;
                    CHR_COMMAND: dec_kind = KIND_COMMAND;
                    CHR_CLOCK:   dec_kind = KIND_CLOCK;
                    CHR_FAN:     dec_kind = KIND_FAN;
                    default:     dec_phase = PH_HDR0;  // unknown type drops the frame
                endcase
            end
            PH_PAY1:
            begin
                case (dec_kind)
                    KIND_SENSOR:
                    begin
                        dec_first = b;
                        dec_phase = PH_PAY2;
                    end
                    KIND_CLOCK:
                    begin
                        dec_first = b;
                        dec_hours = take;
                        dec_phase = PH_PAY2;
                    end
                    KIND_LINK:
                    begin
                        r.kind  = KIND_LINK;
                        r.first = {7'd0, b == LINK_UP_CODE};
                        done    = 1'b1;
                    end
                    KIND_SETTEMP, KIND_COMMAND, KIND_FAN:
                    begin
                        r.kind  = dec_kind;
                        r.first = b;
                        done    = 1'b1;
                    end
                    default: dec_phase = PH_HDR0;
                endcase
            end
            PH_PAY2:
            begin
                if (dec_kind == KIND_CLOCK)
                begin
                    dec_second = b;
                    dec_mins   = take;
                    dec_phase  = PH_PAY3;
                end
                else if (dec_kind == KIND_SENSOR)
                begin
                    r.kind   = KIND_SENSOR;
                    r.first  = dec_first;
                    r.second = b;
                    done     = 1'b1;
                end
                else
                    dec_phase = PH_HDR0;
            end
            PH_PAY3:
            begin
                if (dec_kind == KIND_CLOCK)
                begin
                    r.kind    = KIND_CLOCK;
                    r.first   = dec_first;
                    r.second  = dec_second;
                    r.third   = {1'b0, b} + SEC_OFFSET;
                    r.hours   = dec_hours;
                    r.minutes = dec_mins;
                    done      = 1'b1;
                end
                else
                    dec_phase = PH_HDR0;
            end
            default: dec_phase = PH_HDR0;
        endcase
        if (done)
        begin
            dec_phase = PH_HDR0;
            frames_due.push_back(r);
        end
    endtask

    // Offer one item, wait for the handshake, then feed the decoder.
    // in_valid is left high; the next call or a pause lowers it.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic hold);
        int gap;
        bit taken;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        rx_byte    <= b;
        hold_clock <= hold;
        // sample at the falling edge so the decision never races the DUT
        do
        begin
            @(negedge clk);
            taken = in_valid & in_ready;
            @(posedge clk);
        end
        while (!taken);
        decode_byte(b, hold);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [BYTE_W-1:0] t);
        send_byte(CHR_HDR0, 1'($urandom_range(0, 1)));
        send_byte(CHR_HDR1, 1'($urandom_range(0, 1)));
        send_byte(t, 1'($urandom_range(0, 1)));
    endtask

    function automatic int payload_len(input logic [BYTE_W-1:0] t);
        case (t)
            CHR_SENSOR: return 2;
            CHR_CLOCK:  return 3;
            CHR_LINK, CHR_SETTEMP, CHR_COMMAND, CHR_FAN: return 1;
            default:    return 0;
        endcase
    endfunction

    // Payload bytes lean on the edges and the link-up code
    function automatic logic [BYTE_W-1:0] pick_payload();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return LINK_UP_CODE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input logic [BYTE_W-1:0] t);
        int n;
        n = payload_len(t);
        send_header(t);
        repeat (n) send_byte(pick_payload(), 1'($urandom_range(0, 1)));
    endtask

    // Stop offering items until every expected frame has been taken.
    task automatic wait_frames_drained();
        in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [THIRD_W-1:0] want,
                               input logic [THIRD_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result side: random stalls on out_ready, each taken frame compared with the oldest due.
    initial
    begin : result_check
        int      gap;
        bit      taken;
        result_t seen;
        result_t want;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = idle_on ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                taken          = out_valid & out_ready;
                seen.kind      = frame_kind;
                seen.first     = first_value;
                seen.second    = second_value;
                seen.third     = third_value;
                seen.hours     = hours_taken;
                seen.minutes   = minutes_taken;
                @(posedge clk);
            end
            while (!taken);
            if (frames_due.size() == 0)
            begin
                $error("frame_kind: expected no frame, actual %0d", seen.kind);
                fail_count++;
            end
            else
            begin
                want = frames_due.pop_front();
                check_field("frame_kind", 9'(want.kind), 9'(seen.kind));
                check_field("first_value", 9'(want.first), 9'(seen.first));
                check_field("second_value", 9'(want.second), 9'(seen.second));
                check_field("third_value", want.third, seen.third);
                check_field("hours_taken", 9'(want.hours), 9'(seen.hours));
                check_field("minutes_taken", 9'(want.minutes), 9'(seen.minutes));
            end
        end
    end

    // Every frame kind once, payload extremes, hold on hours/minutes,
    // seconds at the top of its range, and both ways a frame gets dropped.
    task automatic test_directed();
        send_header(CHR_SENSOR);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // hours taken, minutes held off, seconds 0xFF -> 257
        send_header(CHR_CLOCK);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        // repeated 'M' in place of 'A' falls back to header search
        send_byte(CHR_HDR0, 1'b0);
        send_byte(CHR_HDR0, 1'b1);
        // unknown type byte
        send_byte(CHR_HDR0, 1'b0);
        send_byte(CHR_HDR1, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_header(CHR_LINK);
        send_byte(LINK_UP_CODE, 1'b0);
        send_header(CHR_SETTEMP);
        send_byte(8'h00, 1'b1);
        send_header(CHR_COMMAND);
        send_byte(8'h80, 1'b0);
        send_header(CHR_FAN);
        send_byte(8'hFF, 1'b1);
    endtask

    // No gaps on either side, then hold the input until the output has emptied.
    task automatic test_back_to_back();
        int start;
        idle_on = 1'b0;
        start   = bytes_sent;
        while (bytes_sent - start < 250)
            send_frame(TYPE_CHRS[3'($urandom_range(0, 5))]);
        wait_frames_drained();
        idle_on = 1'b1;
    endtask

    // Mostly well-formed frames with random content, mixed with noise,
    // bad types and frames cut short.
    task automatic test_random_traffic();
        int sel;
        while (bytes_sent < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 78)
                send_frame(TYPE_CHRS[3'($urandom_range(0, 5))]);
            else if (sel < 88)
            begin
                // line noise, often a stray 'M' that starts a false header
                if ($urandom_range(0, 3) == 0)
                    send_byte(CHR_HDR0, 1'($urandom_range(0, 1)));
                else
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else if (sel < 94)
                send_frame(8'($urandom_range(0, 255)));  // type may or may not be valid
            else
            begin
                // truncated frame: next header bytes land in its place
                send_header(TYPE_CHRS[3'($urandom_range(0, 5))]);
                if ($urandom_range(0, 1) != 0)
                    send_byte(pick_payload(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_back_to_back();
        test_random_traffic();
        wait_frames_drained();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
